@@ rtl/dse_pkg.sv @@
// ----------------------------------------------------------------------------
// dse_pkg
// Shared types for the drawdown statistics engine: sequencer states and the
// kind of ratio that is in flight.
// ----------------------------------------------------------------------------
package dse_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_RATIO,
    S_DIV_WAIT,
    S_APPLY,
    S_FINAL,
    S_AVG,
    S_AVG_WAIT,
    S_EMIT
  } state_t;

  // What a finished ratio is used for
  typedef enum logic [1:0] {
    K_DD,          // drop of the current sample from the peak
    K_CLOSE_MID,   // depth of an episode closed by a new peak
    K_CLOSE_END    // depth of an episode still open at the final sample
  } kind_t;

endpackage

@@ rtl/dse_divider.sv @@
// ----------------------------------------------------------------------------
// dse_divider
// Shared restoring radix-2 divider, one quotient bit per cycle. The dividend
// shifts out of the top of a register while quotient bits shift into the
// bottom. A ratio starts with the difference as partial remainder and a zero
// dividend; a plain division starts with remainder zero.
// ----------------------------------------------------------------------------
module dse_divider #(
  parameter int DIV_BITS  = 32,
  parameter int QUO_BITS  = 36,
  parameter int STEP_BITS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_BITS-1:0]  rem_init,
  input  logic [QUO_BITS-1:0]  dividend,
  input  logic [DIV_BITS-1:0]  divisor,
  input  logic [STEP_BITS-1:0] steps,
  output logic                 done,
  output logic [QUO_BITS-1:0]  quotient
);

  logic [DIV_BITS-1:0]  rem_r, rem_nxt;
  logic [DIV_BITS-1:0]  div_r, div_nxt;
  logic [QUO_BITS-1:0]  dvd_r, dvd_nxt;
  logic [STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_BITS:0]    trial;
  logic [DIV_BITS:0]    diff;
  logic                 qbit;

  assign trial = {rem_r, dvd_r[QUO_BITS-1]};
  assign diff  = trial - {1'b0, div_r};
  assign qbit  = (trial >= {1'b0, div_r});

  always_comb begin
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = rem_init;
      div_nxt = divisor;
      dvd_nxt = dividend;
      cnt_nxt = steps;
    end else if (cnt_r != '0) begin
      // remainder stays below the divisor, so the low bits always fit
      rem_nxt  = qbit ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      dvd_nxt  = {dvd_r[QUO_BITS-2:0], qbit};
      cnt_nxt  = cnt_r - STEP_BITS'(1);
      done_nxt = (cnt_r == STEP_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (cnt_r == '0))
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cnt_r == '0))
    else $error("divider done with steps left");

endmodule

@@ rtl/drawdown_statistics_engine.sv @@
// ----------------------------------------------------------------------------
// drawdown_statistics_engine
// Running peak, worst drop, mean episode depth and longest run below peak
// over a series of Q16.16 equity samples; one result after the last sample.
// ----------------------------------------------------------------------------
//  channel | direction | fields                                   | handshake
//  in_     | input     | sample_value, last_sample                | valid/ready
//  out_    | output    | max_drawdown, average_drawdown,          | valid/ready
//          |           | max_recovery                             |
//
//  One transaction at a time; in_ready is high only while the sequencer idles.
//  The bit-serial divider computes each ratio but those of a zero peak or a
//  whole loss. The last sample may add one more ratio, for an episode still
//  open, and a division of the depth sum by the episode count with a
//  FRACTION_BITS + COUNT_BITS bit quotient for the mean. The first sample and
//  a new peak with no open episode skip the divider. Reset is synchronous and
//  needs no clearing pass. A result waiting on out_ready stalls only the emit
//  step of the following series; the earlier samples of that series proceed regardless.
// ----------------------------------------------------------------------------
module drawdown_statistics_engine #(
  parameter int VALUE_BITS    = 32,
  parameter int FRACTION_BITS = 16,
  parameter int COUNT_BITS    = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [VALUE_BITS-1:0]    in_sample_value,
  input  logic                     in_last_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FRACTION_BITS-1:0] out_max_drawdown,
  output logic [FRACTION_BITS-1:0] out_average_drawdown,
  output logic [COUNT_BITS-1:0]    out_max_recovery
);

  import dse_pkg::*;

  localparam int SUM_BITS  = FRACTION_BITS + COUNT_BITS;
  localparam int DIV_BITS  = (VALUE_BITS > COUNT_BITS) ? VALUE_BITS : COUNT_BITS;
  localparam int STEP_BITS = $clog2(SUM_BITS + 1);

  state_t                   state_r, state_nxt;
  kind_t                    kind_r, kind_nxt;
  logic [VALUE_BITS-1:0]    sample_r, sample_nxt;
  logic                     last_r, last_nxt;
  logic [VALUE_BITS-1:0]    peak_r, peak_nxt;
  logic [VALUE_BITS-1:0]    trough_r, trough_nxt;
  logic                     open_r, open_nxt;
  logic                     first_r, first_nxt;
  logic [FRACTION_BITS-1:0] worst_r, worst_nxt;
  logic [SUM_BITS-1:0]      sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]    count_r, count_nxt;
  logic [COUNT_BITS-1:0]    run_r, run_nxt;
  logic [COUNT_BITS-1:0]    longest_r, longest_nxt;
  logic [VALUE_BITS-1:0]    op_diff_r, op_diff_nxt;
  logic [VALUE_BITS-1:0]    op_peak_r, op_peak_nxt;
  logic [FRACTION_BITS-1:0] ratio_r, ratio_nxt;
  logic [FRACTION_BITS-1:0] avg_r, avg_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [FRACTION_BITS-1:0] out_dd_r, out_dd_nxt;
  logic [FRACTION_BITS-1:0] out_avg_r, out_avg_nxt;
  logic [COUNT_BITS-1:0]    out_rec_r, out_rec_nxt;

  logic                     div_start;
  logic [DIV_BITS-1:0]      div_rem_init;
  logic [SUM_BITS-1:0]      div_dividend;
  logic [DIV_BITS-1:0]      div_divisor;
  logic [STEP_BITS-1:0]     div_steps;
  logic                     div_done;
  logic [SUM_BITS-1:0]      div_quo;

  logic [COUNT_BITS-1:0]    run_inc;
  logic [COUNT_BITS-1:0]    count_inc;
  logic [SUM_BITS:0]        sum_add;
  logic [SUM_BITS-1:0]      sum_sat;

  assign run_inc   = (&run_r) ? run_r : run_r + COUNT_BITS'(1);
  assign count_inc = (&count_r) ? count_r : count_r + COUNT_BITS'(1);
  assign sum_add   = {1'b0, sum_r} + (SUM_BITS + 1)'(ratio_r);
  assign sum_sat   = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];

  dse_divider #(
    .DIV_BITS  (DIV_BITS),
    .QUO_BITS  (SUM_BITS),
    .STEP_BITS (STEP_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    peak_nxt      = peak_r;
    trough_nxt    = trough_r;
    open_nxt      = open_r;
    first_nxt     = first_r;
    worst_nxt     = worst_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    run_nxt       = run_r;
    longest_nxt   = longest_r;
    op_diff_nxt   = op_diff_r;
    op_peak_nxt   = op_peak_r;
    ratio_nxt     = ratio_r;
    avg_nxt       = avg_r;
    out_dd_nxt    = out_dd_r;
    out_avg_nxt   = out_avg_r;
    out_rec_nxt   = out_rec_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_start     = 1'b0;
    div_rem_init  = '0;
    div_dividend  = '0;
    div_divisor   = '0;
    div_steps     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample_value;
          last_nxt   = in_last_sample;
          state_nxt  = S_EVAL;
        end
      end

      S_EVAL: begin
        priority if (!first_r) begin
          first_nxt  = 1'b1;
          peak_nxt   = sample_r;
          trough_nxt = sample_r;
          open_nxt   = 1'b0;
          run_nxt    = '0;
          state_nxt  = S_FINAL;
        end else if (sample_r > peak_r) begin
          // new peak: close the open episode against the old peak
          peak_nxt    = sample_r;
          trough_nxt  = sample_r;
          run_nxt     = '0;
          op_diff_nxt = peak_r - trough_r;
          op_peak_nxt = peak_r;
          kind_nxt    = K_CLOSE_MID;
          state_nxt   = open_r ? S_RATIO : S_FINAL;
        end else begin
          open_nxt = 1'b1;
          if (sample_r < trough_r) begin
            trough_nxt = sample_r;
          end
          if (sample_r < peak_r) begin
            run_nxt = run_inc;
            if (run_inc > longest_r) begin
              longest_nxt = run_inc;
            end
          end else begin
            run_nxt = '0;
          end
          op_diff_nxt = peak_r - sample_r;
          op_peak_nxt = peak_r;
          kind_nxt    = K_DD;
          state_nxt   = S_RATIO;
        end
      end

      S_RATIO: begin
        priority if (op_peak_r == '0) begin
          ratio_nxt = '0;
          state_nxt = S_APPLY;
        end else if (op_diff_r >= op_peak_r) begin
          ratio_nxt = '1;
          state_nxt = S_APPLY;
        end else begin
          div_start    = 1'b1;
          div_rem_init = DIV_BITS'(op_diff_r);
          div_divisor  = DIV_BITS'(op_peak_r);
          div_steps    = STEP_BITS'(FRACTION_BITS);
          state_nxt    = S_DIV_WAIT;
        end
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          ratio_nxt = div_quo[FRACTION_BITS-1:0];
          state_nxt = S_APPLY;
        end
      end

      S_APPLY: begin
        unique case (kind_r)
          K_DD: begin
            if (ratio_r > worst_r) begin
              worst_nxt = ratio_r;
            end
            state_nxt = S_FINAL;
          end
          K_CLOSE_MID: begin
            sum_nxt   = sum_sat;
            count_nxt = count_inc;
            open_nxt  = 1'b0;
            state_nxt = S_FINAL;
          end
          K_CLOSE_END: begin
            sum_nxt   = sum_sat;
            count_nxt = count_inc;
            open_nxt  = 1'b0;
            state_nxt = S_AVG;
          end
          default: state_nxt = S_FINAL;
        endcase
      end

      S_FINAL: begin
        priority if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (open_r) begin
          op_diff_nxt = peak_r - trough_r;
          op_peak_nxt = peak_r;
          kind_nxt    = K_CLOSE_END;
          state_nxt   = S_RATIO;
        end else begin
          state_nxt = S_AVG;
        end
      end

      S_AVG: begin
        if (count_r == '0) begin
          avg_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          div_start    = 1'b1;
          div_dividend = sum_r;
          div_divisor  = DIV_BITS'(count_r);
          div_steps    = STEP_BITS'(SUM_BITS);
          state_nxt    = S_AVG_WAIT;
        end
      end

      S_AVG_WAIT: begin
        if (div_done) begin
          avg_nxt   = (div_quo[SUM_BITS-1:FRACTION_BITS] != '0) ? '1
                                                                : div_quo[FRACTION_BITS-1:0];
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dd_nxt    = worst_r;
          out_avg_nxt   = avg_r;
          out_rec_nxt   = longest_r;
          // series done: back to the reset picture
          peak_nxt      = '0;
          trough_nxt    = '0;
          open_nxt      = 1'b0;
          first_nxt     = 1'b0;
          worst_nxt     = '0;
          sum_nxt       = '0;
          count_nxt     = '0;
          run_nxt       = '0;
          longest_nxt   = '0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      peak_r      <= '0;
      trough_r    <= '0;
      open_r      <= 1'b0;
      first_r     <= 1'b0;
      worst_r     <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      run_r       <= '0;
      longest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      peak_r      <= peak_nxt;
      trough_r    <= trough_nxt;
      open_r      <= open_nxt;
      first_r     <= first_nxt;
      worst_r     <= worst_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      run_r       <= run_nxt;
      longest_r   <= longest_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r    <= kind_nxt;
    sample_r  <= sample_nxt;
    last_r    <= last_nxt;
    op_diff_r <= op_diff_nxt;
    op_peak_r <= op_peak_nxt;
    ratio_r   <= ratio_nxt;
    avg_r     <= avg_nxt;
    out_dd_r  <= out_dd_nxt;
    out_avg_r <= out_avg_nxt;
    out_rec_r <= out_rec_nxt;
  end

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_max_drawdown     = out_dd_r;
  assign out_average_drawdown = out_avg_r;
  assign out_max_recovery     = out_rec_r;

  a_run_le_longest: assert property (@(posedge clk) disable iff (!rst_n)
    run_r <= longest_r)
    else $error("current run exceeds longest run");

  a_worst_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EMIT) |=> (worst_r >= $past(worst_r)))
    else $error("worst drawdown decreased within a series");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && !out_ready)) |-> (state_r == S_EMIT))
    else $error("result loaded outside emit state");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_WAIT || state_r == S_AVG_WAIT))
    else $error("divider finished while sequencer not waiting");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for drawdown_statistics_engine. Drives series of Q16.16 equity
// samples over the valid/ready input, keeps a scoreboard that predicts the
// worst drop, mean episode depth and longest run below peak for each series,
// and compares every result transaction field by field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int TARGET_SAMPLES = 1850;
  localparam int QUIET_AFTER    = 1650;
  localparam int HOLD_AT        = 500;
  localparam int HOLD_CYCLES    = 3000;
  localparam int DRAIN_AT       = 1100;
  localparam int SETTLE_CYCLES  = 120;
  localparam int SUM_W          = 36;

  // sample patterns for the random series
  localparam int PAT_WALK  = 0;
  localparam int PAT_WILD  = 1;
  localparam int PAT_TINY  = 2;
  localparam int PAT_CRASH = 3;

  typedef struct {
    logic [15:0] max_dd;
    logic [15:0] avg_dd;
    logic [19:0] max_rec;
  } stats_t;

  class drawdown_scoreboard;
    logic [31:0]      peak;
    logic [31:0]      trough;
    bit               in_episode;
    bit               started;
    logic [15:0]      worst;
    logic [SUM_W-1:0] depth_sum;
    logic [19:0]      episodes;
    logic [19:0]      run_len;
    logic [19:0]      longest;
    stats_t           expected_q[$];
    int               failures;

    function new();
      failures = 0;
      clear_series();
    endfunction

    function void clear_series();
      peak       = '0;
      trough     = '0;
      in_episode = 0;
      started    = 0;
      worst      = '0;
      depth_sum  = '0;
      episodes   = '0;
      run_len    = '0;
      longest    = '0;
    endfunction

    // diff / ref_peak as truncated Q0.16; a whole loss pins to all ones
    function logic [15:0] drop_fraction(logic [31:0] diff, logic [31:0] ref_peak);
      logic [47:0] num;
      logic [47:0] quo;
      if (ref_peak == 0) return '0;
      if (diff >= ref_peak) return '1;
      num = {diff, 16'h0000};
      quo = num / {16'h0000, ref_peak};
      return quo[15:0];
    endfunction

    function void close_episode();
      logic [15:0]      d;
      logic [SUM_W-1:0] lim;
      d   = drop_fraction(peak - trough, peak);
      lim = '1;
      if (lim - depth_sum < {20'h0, d}) depth_sum = lim;
      else depth_sum = depth_sum + {20'h0, d};
      if (episodes != '1) episodes = episodes + 1'b1;
      in_episode = 0;
    endfunction

    function void note_sample(logic [31:0] v, bit last);
      stats_t           r;
      logic [15:0]      dd;
      logic [SUM_W-1:0] mean;
      if (!started) begin
        started    = 1;
        peak       = v;
        trough     = v;
        in_episode = 0;
        run_len    = '0;
      end else if (v > peak) begin
        if (in_episode) close_episode();
        peak    = v;
        trough  = v;
        run_len = '0;
      end else begin
        // a sample level with the peak still opens an episode of depth zero
        in_episode = 1;
        if (v < trough) trough = v;
        if (v < peak) begin
          if (run_len != '1) run_len = run_len + 1'b1;
          if (run_len > longest) longest = run_len;
        end else begin
          run_len = '0;
        end
      end
      dd = drop_fraction(peak - v, peak);
      if (dd > worst) worst = dd;
      if (!last) return;
      if (in_episode) close_episode();
      mean = (episodes == 0) ? '0 : depth_sum / {16'h0, episodes};
      r.max_dd  = worst;
      r.avg_dd  = (mean > 16'hFFFF) ? 16'hFFFF : mean[15:0];
      r.max_rec = longest;
      expected_q.push_back(r);
      clear_series();
    endfunction

    function void check_result(logic [15:0] max_dd, logic [15:0] avg_dd,
                               logic [19:0] max_rec);
      stats_t e;
      if (expected_q.size() == 0) begin
        if (failures < 10)
          $display("%0t: result with nothing expected: dd=%h avg=%h rec=%h",
                   $realtime, max_dd, avg_dd, max_rec);
        failures++;
        return;
      end
      e = expected_q.pop_front();
      if (e.max_dd !== max_dd || e.avg_dd !== avg_dd || e.max_rec !== max_rec) begin
        if (failures < 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  max_drawdown     exp %h got %h", e.max_dd, max_dd);
          $display("  average_drawdown exp %h got %h", e.avg_dd, avg_dd);
          $display("  max_recovery     exp %h got %h", e.max_rec, max_rec);
        end
        failures++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_sample_value;
  logic        in_last_sample;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_max_drawdown;
  logic [15:0] out_average_drawdown;
  logic [19:0] out_max_recovery;

  drawdown_statistics_engine dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sample_value      (in_sample_value),
    .in_last_sample       (in_last_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_max_drawdown     (out_max_drawdown),
    .out_average_drawdown (out_average_drawdown),
    .out_max_recovery     (out_max_recovery)
  );

  drawdown_scoreboard sb;
  int samples_sent = 0;
  int tx_level     = 0;
  int rx_level     = 2;
  bit quiet        = 0;
  bit hold_req     = 0;
  int cycles       = 0;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random ready bursts, one long hold-off
  initial begin
    int  burst;
    bit  hold_done;
    burst     = 0;
    hold_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (quiet) begin
        out_ready = 1'b1;
      end else if (burst > 0) begin
        out_ready = 1'b0;
        burst--;
      end else if (rx_level != 0 && $urandom_range(0, 15) < rx_level) begin
        burst     = $urandom_range(1, 19) - 1;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_max_drawdown, out_average_drawdown, out_max_recovery);
  end

  // returns at the edge where the transaction is taken
  task automatic send_sample(input logic [31:0] v, input bit last);
    @(negedge clk);
    in_valid        = 1'b1;
    in_sample_value = v;
    in_last_sample  = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(v, last);
    samples_sent++;
  endtask

  task automatic tx_pause();
    int n;
    if (!quiet && tx_level != 0 && $urandom_range(0, 15) < tx_level) begin
      n = $urandom_range(1, 19);
      repeat (n) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
  endtask

  task automatic run_series(input int len, input int pattern);
    logic [31:0] level;
    logic [31:0] top;
    logic [31:0] delta;
    logic [31:0] v;
    int          k;
    level = $urandom;
    top   = 0;
    for (k = 0; k < len; k++) begin
      delta = $urandom_range(0, 32'h0010_0000);
      if ($urandom_range(0, 1)) level = (level > 32'hFFFF_FFFF - delta) ? 32'hFFFF_FFFF
                                                                           : level + delta;
      else level = (level < delta) ? 32'h0 : level - delta;
      case (pattern)
        PAT_WILD:  v = $urandom;
        PAT_TINY:  v = $urandom_range(0, 7);
        PAT_CRASH: v = ($urandom_range(0, 3) == 0) ? 32'h0 : level;
        default:   v = level;
      endcase
      // revisit the peak now and then so level-with-peak samples show up
      if (k > 0 && $urandom_range(0, 7) == 0) v = top;
      if (k == 0 || v > top) top = v;
      tx_pause();
      send_sample(v, k == len - 1);
    end
  endtask

  initial begin
    int  len;
    bit  drained;
    drained         = 0;
    sb              = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample_value = '0;
    in_last_sample  = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // single-sample series
    send_sample(32'h0001_0000, 1);
    // zero peak episodes, then a new peak with an episode open at the end
    send_sample(32'h0, 0);
    send_sample(32'h0, 0);
    send_sample(32'h5, 0);
    send_sample(32'h3, 1);
    // full-scale peak, level with peak, total loss, run open at the end
    send_sample(32'hFFFF_FFFF, 0);
    send_sample(32'hFFFF_FFFF, 0);
    send_sample(32'h0, 0);
    send_sample(32'h8000_0000, 1);
    // episodes closed by new peaks
    send_sample(32'd100, 0);
    send_sample(32'd50, 0);
    send_sample(32'd120, 0);
    send_sample(32'd60, 0);
    send_sample(32'd60, 0);
    send_sample(32'd130, 0);
    send_sample(32'd10, 1);
    // a return to the peak breaks the run
    send_sample(32'h7FFF_FFFF, 0);
    send_sample(32'h1234_5678, 0);
    send_sample(32'h7FFF_FFFF, 0);
    send_sample(32'h0000_0001, 1);
    send_sample(32'h0, 1);

    while (samples_sent < TARGET_SAMPLES) begin
      quiet    = samples_sent >= QUIET_AFTER;
      tx_level = $urandom_range(0, 4);
      rx_level = $urandom_range(0, 4);
      if (samples_sent >= HOLD_AT) hold_req = 1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      run_series(len, $urandom_range(PAT_WALK, PAT_CRASH));
      if (!drained && samples_sent >= DRAIN_AT) begin
        drained = 1;
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dse_pkg.sv
rtl/dse_divider.sv
rtl/drawdown_statistics_engine.sv
verif/tb.sv
